[src/cahs_pkg.sv]
// ----------------------------------------------------------------------------
// Control authority handoff table package
// Shared record, result and control types plus opcode, state and status codes.
// ----------------------------------------------------------------------------
package cahs_pkg;

   localparam int KeyWidth   = 16;
   localparam int EpochWidth = 32;
   localparam int TimeWidth  = 32;

   // Opcodes of an input beat.
   localparam logic [2:0] OP_REQUEST  = 3'd0;
   localparam logic [2:0] OP_RELEASE  = 3'd1;
   localparam logic [2:0] OP_GRANT    = 3'd2;
   localparam logic [2:0] OP_RELEASED = 3'd3;
   localparam logic [2:0] OP_VALIDATE = 3'd4;
   localparam logic [2:0] OP_FORCE    = 3'd5;
   localparam logic [2:0] OP_SWEEP    = 3'd6;
   localparam logic [2:0] OP_QUERY    = 3'd7;

   // Record states.
   localparam logic [1:0] ST_AUTO = 2'd0;
   localparam logic [1:0] ST_PEND = 2'd1;
   localparam logic [1:0] ST_SUP  = 2'd2;
   localparam logic [1:0] ST_REL  = 2'd3;

   // Response status codes.
   localparam logic [2:0] STS_OK       = 3'd0;
   localparam logic [2:0] STS_FULL     = 3'd1;
   localparam logic [2:0] STS_NOTFOUND = 3'd2;
   localparam logic [2:0] STS_BUSY     = 3'd3;
   localparam logic [2:0] STS_PERM     = 3'd4;
   localparam logic [2:0] STS_PROTO    = 3'd5;

   // Flag bit positions.
   localparam int FL_ACK = 0;
   localparam int FL_ONL = 1;
   localparam int FL_CTL = 2;

   localparam logic [TimeWidth-1:0]  TimeoutReset = 32'd5000;
   localparam logic [EpochWidth-1:0] EpochStart   = 32'd1;

   typedef struct packed {
      logic                  valid;
      logic [KeyWidth-1:0]   key;
      logic [1:0]            state;
      logic [EpochWidth-1:0] epoch;
      logic [TimeWidth-1:0]  rtime;
      logic [2:0]            flags;
   } record_type;

   typedef struct packed {
      logic                  kind;
      logic [2:0]            status;
      logic [KeyWidth-1:0]   key;
      logic [1:0]            state_before;
      logic [1:0]            state_after;
      logic [EpochWidth-1:0] epoch;
      logic [2:0]            flags;
      logic                  last;
   } result_type;

   typedef struct packed {
      record_type rec;
      logic       note_valid;
      result_type note;
      logic       hit;
      result_type resp;
   } step_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_SCAN,
      CTL_ALLOC,
      CTL_FINISH
   } ctl_state_type;

endpackage

[src/cahs_if.sv]
// ----------------------------------------------------------------------------
// Control authority handoff table channels
// Valid/ready channel interfaces for requests, results and the timeout CSR.
// ----------------------------------------------------------------------------
interface cahs_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [15:0] station_key;
   logic [31:0] epoch_in;
   logic [31:0] now_ms;

   modport source (output valid, opcode, station_key, epoch_in, now_ms, input ready);
   modport sink   (input valid, opcode, station_key, epoch_in, now_ms, output ready);
endinterface

interface cahs_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [2:0]  status;
   logic [15:0] station_key_out;
   logic [1:0]  state_before;
   logic [1:0]  state_after;
   logic [31:0] epoch;
   logic        acknowledged;
   logic        ctrl_online;
   logic        holder_is_controller;
   logic        last;

   modport source (output valid, kind, status, station_key_out, state_before, state_after,
                   epoch, acknowledged, ctrl_online, holder_is_controller, last,
                   input ready);
   modport sink   (input valid, kind, status, station_key_out, state_before, state_after,
                   epoch, acknowledged, ctrl_online, holder_is_controller, last,
                   output ready);
endinterface

interface cahs_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

[src/cahs_cell.sv]
// ----------------------------------------------------------------------------
// Control authority handoff table cell
// Holds one station record and takes its neighbor's record on every shift.
// ----------------------------------------------------------------------------
module cahs_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  cahs_pkg::record_type d,
   output cahs_pkg::record_type q
);

   logic                 valid_ff;
   cahs_pkg::record_type data_ff;

   // The valid bit is control state and clears at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= d.valid;
      end
   end

   // Record payload moves along the ring without reset.
   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= d;
      end
   end

   always_comb begin
      q       = data_ff;
      q.valid = valid_ff;
   end

endmodule

[src/cahs_step.sv]
// ----------------------------------------------------------------------------
// Control authority handoff table record step
// Applies the current operation to the record leaving the end of the ring.
// ----------------------------------------------------------------------------
module cahs_step (
   input  cahs_pkg::record_type rec_in,
   input  logic [2:0]           opcode,
   input  logic [15:0]          key,
   input  logic [31:0]          epoch_in,
   input  logic [31:0]          now_ms,
   input  logic [31:0]          timeout,
   input  logic                 alloc_mode,
   input  logic                 done,
   output cahs_pkg::step_type   step
);

   cahs_pkg::record_type r;
   logic [2:0]           sts;
   logic [31:0]          elapsed;
   logic                 expired;

   always_comb begin
      r       = rec_in;
      sts     = cahs_pkg::STS_OK;
      elapsed = now_ms - rec_in.rtime;
      expired = elapsed > timeout;
      step.hit = 1'b0;

      if (alloc_mode) begin
         // Second pass: the first free slot takes the new station, already pending.
         if (!rec_in.valid && !done) begin
            step.hit = 1'b1;
            r.valid  = 1'b1;
            r.key    = key;
            r.state  = cahs_pkg::ST_PEND;
            r.epoch  = cahs_pkg::EpochStart;
            r.rtime  = now_ms;
            r.flags  = 3'b000;
            r.flags[cahs_pkg::FL_ONL] = 1'b1;
         end
      end else if (opcode == cahs_pkg::OP_SWEEP) begin
         // Timed out handoffs and releases fall back to autonomous.
         if (rec_in.valid && expired) begin
            if (rec_in.state == cahs_pkg::ST_PEND) begin
               r.state = cahs_pkg::ST_AUTO;
               r.flags[cahs_pkg::FL_ONL] = 1'b0;
            end else if (rec_in.state == cahs_pkg::ST_REL) begin
               r.state = cahs_pkg::ST_AUTO;
               r.epoch = rec_in.epoch + 32'd1;
            end
         end
      end else if (rec_in.valid && rec_in.key == key) begin
         step.hit = 1'b1;
         case (opcode)
            cahs_pkg::OP_REQUEST: begin
               if (rec_in.state == cahs_pkg::ST_PEND) begin
                  sts = cahs_pkg::STS_BUSY;
               end else if (rec_in.state != cahs_pkg::ST_SUP) begin
                  r.state = cahs_pkg::ST_PEND;
                  r.rtime = now_ms;
                  r.flags[cahs_pkg::FL_ACK] = 1'b0;
                  r.flags[cahs_pkg::FL_ONL] = 1'b1;
               end
            end
            cahs_pkg::OP_RELEASE: begin
               if (rec_in.state != cahs_pkg::ST_SUP) begin
                  sts = cahs_pkg::STS_PERM;
               end else begin
                  r.state = cahs_pkg::ST_REL;
                  r.rtime = now_ms;
               end
            end
            cahs_pkg::OP_GRANT: begin
               if (rec_in.state != cahs_pkg::ST_PEND) begin
                  sts = cahs_pkg::STS_PROTO;
               end else begin
                  r.epoch = epoch_in;
                  r.state = cahs_pkg::ST_SUP;
                  r.flags[cahs_pkg::FL_ACK] = 1'b1;
                  r.flags[cahs_pkg::FL_CTL] = 1'b1;
               end
            end
            cahs_pkg::OP_RELEASED: begin
               r.epoch = epoch_in;
               r.state = cahs_pkg::ST_AUTO;
               r.flags[cahs_pkg::FL_ACK] = 1'b0;
               r.flags[cahs_pkg::FL_CTL] = 1'b0;
            end
            cahs_pkg::OP_VALIDATE: begin
               if (rec_in.state != cahs_pkg::ST_SUP ||
                   (epoch_in != 32'd0 && epoch_in < rec_in.epoch)) begin
                  sts = cahs_pkg::STS_PERM;
               end
            end
            cahs_pkg::OP_FORCE: begin
               r.state = cahs_pkg::ST_AUTO;
               r.epoch = rec_in.epoch + 32'd1;
               r.flags[cahs_pkg::FL_ONL] = 1'b0;
               r.flags[cahs_pkg::FL_CTL] = 1'b0;
            end
            default: begin
               sts = cahs_pkg::STS_OK;
            end
         endcase
      end

      // A notice goes out whenever the record's state moved or a free slot was allocated.
      step.rec               = r;
      step.note_valid        = r.valid && (r.state != rec_in.state || !rec_in.valid);
      step.note.kind         = 1'b1;
      step.note.status       = cahs_pkg::STS_OK;
      step.note.key          = r.key;
      step.note.state_before = rec_in.valid ? rec_in.state : cahs_pkg::ST_AUTO;
      step.note.state_after  = r.state;
      step.note.epoch        = r.epoch;
      step.note.flags        = r.flags;
      step.note.last         = 1'b0;

      step.resp            = step.note;
      step.resp.kind       = 1'b0;
      step.resp.status     = sts;
      step.resp.last       = 1'b1;
   end

endmodule

[src/control_authority_handoff_table.sv]
// ----------------------------------------------------------------------------
// Control authority handoff table
// Station records circulate through a ring of cells; one step unit serves them.
// ----------------------------------------------------------------------------
// Flow: each item takes a lookup pass round the ring (plus an allocation pass for a
// request that finds no record), then a finish state; result stalls hold the ring.
// Throughput: one item at a time; the ring rotates one slot per cycle unless stalled.
// Reset: all records invalid, timeout register at 5000 ms, controller idle.
module control_authority_handoff_table #(
   parameter int ENTRIES = 32
) (
   input logic       clock,
   input logic       reset,
   cahs_req_if.sink  req_chan,
   cahs_rsp_if.source rsp_chan,
   cahs_csr_if.sink  csr_chan
);

   localparam int CW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [CW-1:0] LastIdx = CW'(ENTRIES - 1);

   cahs_pkg::record_type    ring [ENTRIES];
   cahs_pkg::step_type      step;
   cahs_pkg::ctl_state_type ctl_ff, ctl_in;
   cahs_pkg::result_type    rsp_ff, rsp_in, hold_ff, hold_in;

   logic [31:0]   timeout_ff;
   logic [2:0]    op_ff;
   logic [15:0]   key_ff;
   logic [31:0]   ep_ff, now_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          found_ff, found_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free, shift, accept;

   // Timeout register, ready for a write beat whenever out of reset.
   assign csr_chan.ready = !reset;
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= cahs_pkg::TimeoutReset;
      end else if (csr_chan.valid) begin
         timeout_ff <= csr_chan.data;
      end
   end

   // Ring of record cells; the step unit feeds the head from the tail.
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      cahs_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .d     ((g == 0) ? step.rec : ring[(g == 0) ? 0 : g - 1]),
         .q     (ring[g])
      );
   end

   cahs_step u_step (
      .rec_in     (ring[ENTRIES-1]),
      .opcode     (op_ff),
      .key        (key_ff),
      .epoch_in   (ep_ff),
      .now_ms     (now_ff),
      .timeout    (timeout_ff),
      .alloc_mode (ctl_ff == cahs_pkg::CTL_ALLOC),
      .done       (found_ff),
      .step       (step)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (ctl_ff == cahs_pkg::CTL_IDLE) && !reset;
   assign accept         = req_chan.valid && req_chan.ready;
   assign shift          = out_free &&
                           (ctl_ff inside {cahs_pkg::CTL_SCAN, cahs_pkg::CTL_ALLOC});

   // Latch the item on acceptance.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_chan.opcode;
         key_ff <= req_chan.station_key;
         ep_ff  <= req_chan.epoch_in;
         now_ff <= req_chan.now_ms;
      end
   end

   // Controller state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= cahs_pkg::CTL_IDLE;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   // Next state: one pass to look up or sweep, a second to allocate.
   always_comb begin
      ctl_in       = ctl_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (ctl_ff)
         cahs_pkg::CTL_IDLE: begin
            if (accept) begin
               ctl_in   = cahs_pkg::CTL_SCAN;
               cnt_in   = '0;
               found_in = 1'b0;
            end
         end
         cahs_pkg::CTL_SCAN, cahs_pkg::CTL_ALLOC: begin
            if (shift) begin
               if (step.note_valid) begin
                  rsp_in       = step.note;
                  rsp_valid_in = 1'b1;
               end
               if (step.hit) begin
                  found_in = 1'b1;
                  hold_in  = step.resp;
               end
               cnt_in = cnt_ff + CW'(1);
               if (cnt_ff == LastIdx) begin
                  cnt_in = '0;
                  if (ctl_ff == cahs_pkg::CTL_SCAN && op_ff == cahs_pkg::OP_REQUEST &&
                      !found_ff && !step.hit) begin
                     ctl_in = cahs_pkg::CTL_ALLOC;
                  end else begin
                     ctl_in = cahs_pkg::CTL_FINISH;
                  end
               end
            end
         end
         cahs_pkg::CTL_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.last  = 1'b1;
               if (op_ff != cahs_pkg::OP_SWEEP) begin
                  if (found_ff) begin
                     rsp_in = hold_ff;
                  end else begin
                     rsp_in.key    = key_ff;
                     rsp_in.status = (op_ff == cahs_pkg::OP_REQUEST) ?
                                     cahs_pkg::STS_FULL : cahs_pkg::STS_NOTFOUND;
                  end
               end
               ctl_in = cahs_pkg::CTL_IDLE;
            end
         end
         default: begin
            ctl_in = cahs_pkg::CTL_IDLE;
         end
      endcase
   end

   // Result beat fields.
   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.kind                 = rsp_ff.kind;
   assign rsp_chan.status               = rsp_ff.status;
   assign rsp_chan.station_key_out      = rsp_ff.key;
   assign rsp_chan.state_before         = rsp_ff.state_before;
   assign rsp_chan.state_after          = rsp_ff.state_after;
   assign rsp_chan.epoch                = rsp_ff.epoch;
   assign rsp_chan.acknowledged         = rsp_ff.flags[cahs_pkg::FL_ACK];
   assign rsp_chan.ctrl_online          = rsp_ff.flags[cahs_pkg::FL_ONL];
   assign rsp_chan.holder_is_controller = rsp_ff.flags[cahs_pkg::FL_CTL];
   assign rsp_chan.last                 = rsp_ff.last;

endmodule
